>>> rtl/quaternion_to_rotation_matrix_assert.svh
// Assertion macros for the quaternion to rotation matrix block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QRM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrm assertion failed");

// Next-cycle implication, always checked.
`define QRM_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("qrm assertion failed");

`endif

>>> rtl/qrm_pkg.sv
// Shared constants and types for the quaternion to rotation matrix block.
`default_nettype none
package qrm_pkg;
   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int PROD_W    = 2 * IN_W;
   localparam int S_W       = PROD_W + 1;
   localparam int NUM_W     = PROD_W + 2;
   localparam int QB_W      = FRAC_BITS + 1;
   localparam int WIDE_W    = 40;
   localparam int LANES     = 9;
   // accept->products, sums, lane prep, QB_W divide steps, rounding
   localparam int LAT       = QB_W + 4;

   typedef logic signed [IN_W-1:0]   comp_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [NUM_W-1:0]  num_type;
   typedef logic [S_W-1:0]           norm_type;
   typedef logic [OUT_W-1:0]         entry_type;
endpackage
`default_nettype wire

>>> rtl/qrm_if.sv
// Valid/ready channel interfaces for quaternion requests and matrix results.
`default_nettype none
interface quat_if;
   logic valid;
   logic ready;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface rot_if;
   logic valid;
   logic ready;
   logic signed [15:0] rot_00;
   logic signed [15:0] rot_01;
   logic signed [15:0] rot_02;
   logic signed [15:0] rot_10;
   logic signed [15:0] rot_11;
   logic signed [15:0] rot_12;
   logic signed [15:0] rot_20;
   logic signed [15:0] rot_21;
   logic signed [15:0] rot_22;
   logic zero_norm;
   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, zero_norm, input ready);
   modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, zero_norm, output ready);
endinterface
`default_nettype wire

>>> rtl/qrm_front.sv
// Product and sum stages: squared norm and the nine matrix numerators.
`default_nettype none
module qrm_front (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire qrm_pkg::comp_type w,
   input  wire qrm_pkg::comp_type x,
   input  wire qrm_pkg::comp_type y,
   input  wire qrm_pkg::comp_type z,
   output qrm_pkg::norm_type      norm,
   output qrm_pkg::num_type       num [qrm_pkg::LANES]
);
   qrm_pkg::prod_type ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   qrm_pkg::norm_type norm_ff;
   qrm_pkg::num_type  num_ff [qrm_pkg::LANES];
   qrm_pkg::num_type  sn, e_ww, e_xx, e_yy, e_zz, e_xy, e_zw, e_xz, e_yw, e_yz, e_xw;

   // stage A: ten 16x16 products
   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff <= w * w;
         xx_ff <= x * x;
         yy_ff <= y * y;
         zz_ff <= z * z;
         xy_ff <= x * y;
         zw_ff <= z * w;
         xz_ff <= x * z;
         yw_ff <= y * w;
         yz_ff <= y * z;
         xw_ff <= x * w;
      end
   end

   always_comb begin
      e_ww = qrm_pkg::NUM_W'(ww_ff);
      e_xx = qrm_pkg::NUM_W'(xx_ff);
      e_yy = qrm_pkg::NUM_W'(yy_ff);
      e_zz = qrm_pkg::NUM_W'(zz_ff);
      e_xy = qrm_pkg::NUM_W'(xy_ff);
      e_zw = qrm_pkg::NUM_W'(zw_ff);
      e_xz = qrm_pkg::NUM_W'(xz_ff);
      e_yw = qrm_pkg::NUM_W'(yw_ff);
      e_yz = qrm_pkg::NUM_W'(yz_ff);
      e_xw = qrm_pkg::NUM_W'(xw_ff);
      sn   = e_ww + e_xx + e_yy + e_zz;
   end

   // stage B: norm and numerators
   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff   <= qrm_pkg::S_W'(sn);
         num_ff[0] <= sn - ((e_yy + e_zz) <<< 1);
         num_ff[1] <= (e_xy - e_zw) <<< 1;
         num_ff[2] <= (e_xz + e_yw) <<< 1;
         num_ff[3] <= (e_xy + e_zw) <<< 1;
         num_ff[4] <= sn - ((e_xx + e_zz) <<< 1);
         num_ff[5] <= (e_yz - e_xw) <<< 1;
         num_ff[6] <= (e_xz - e_yw) <<< 1;
         num_ff[7] <= (e_yz + e_xw) <<< 1;
         num_ff[8] <= sn - ((e_xx + e_yy) <<< 1);
      end
   end

   assign norm = norm_ff;
   assign num  = num_ff;
endmodule
`default_nettype wire

>>> rtl/qrm_div_lane.sv
// One matrix entry: restoring divider, one quotient bit per stage, then rounding.
`default_nettype none
module qrm_div_lane (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire qrm_pkg::norm_type norm,
   input  wire qrm_pkg::num_type  num,
   output qrm_pkg::entry_type     entry
);
   localparam int QB = qrm_pkg::QB_W;

   logic [qrm_pkg::S_W-1:0] rem_ff  [QB+1];
   logic [QB-1:0]           quo_ff  [QB+1];
   qrm_pkg::norm_type       norm_ff [QB+1];
   logic                    neg_ff  [QB+1];
   logic                    sat_ff  [QB+1];
   qrm_pkg::entry_type      entry_ff;

   qrm_pkg::num_type        mag;
   logic [qrm_pkg::S_W:0]   r2      [QB];
   logic                    fit     [QB];
   logic [QB:0]             qsum;
   logic [QB-1:0]           qrnd;
   logic [qrm_pkg::WIDE_W-1:0] wmag, wres;

   // prep stage: sign, magnitude, saturation when |num| >= s
   assign mag = num[qrm_pkg::NUM_W-1] ? -num : num;

   // divide steps: shift remainder, subtract norm when it fits
   always_comb begin
      for (int k = 0; k < QB; k++) begin
         r2[k]  = {rem_ff[k], 1'b0};
         fit[k] = r2[k] >= {1'b0, norm_ff[k]};
      end
   end

   // prep register, then one quotient bit per stage
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= mag[qrm_pkg::S_W-1:0];
         quo_ff[0]  <= '0;
         norm_ff[0] <= norm;
         neg_ff[0]  <= num[qrm_pkg::NUM_W-1];
         sat_ff[0]  <= $unsigned(mag) >= qrm_pkg::NUM_W'(norm);
         for (int k = 0; k < QB; k++) begin
            rem_ff[k+1]  <= fit[k] ? qrm_pkg::S_W'(r2[k] - {1'b0, norm_ff[k]})
                                   : qrm_pkg::S_W'(r2[k]);
            quo_ff[k+1]  <= {quo_ff[k][QB-2:0], fit[k]};
            norm_ff[k+1] <= norm_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            sat_ff[k+1]  <= sat_ff[k];
         end
      end
   end

   // rounding: extra quotient bit rounds half away from zero
   always_comb begin
      qsum = {1'b0, quo_ff[QB]} + (QB+1)'(1);
      qrnd = qsum[QB:1];
      wmag = sat_ff[QB] ? qrm_pkg::WIDE_W'(1) << qrm_pkg::FRAC_BITS
                        : qrm_pkg::WIDE_W'(qrnd);
      wres = neg_ff[QB] ? -wmag : wmag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         entry_ff <= wres[qrm_pkg::OUT_W-1:0];
      end
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

>>> rtl/quaternion_to_rotation_matrix.sv
// Top level: quaternion in, normalized 3x3 rotation matrix out.
//
// Usage: requests arrive on req (quat_if, valid/ready) as four signed
// components with FRAC_BITS fraction bits; results leave on rsp (rot_if)
// as nine row-major entries in the same format plus a zero_norm flag.
// A request is taken when valid and ready are both high.
// The pipeline has one product stage, one sum stage, one sign/magnitude
// stage, FRAC_BITS + 1 divider stages producing one quotient bit each,
// and one rounding stage. Throughput is one request per cycle while the
// receiver does not stall; the nine dividers are fully pipelined.
// When the receiver stalls with a result pending, the whole pipeline holds
// and req.ready drops in the same cycle; no request is lost or repeated.
// A zero quaternion yields an all-zero matrix with zero_norm set.
// Synchronous reset clears only the valid bits; data registers are not reset.
`default_nettype none
module quaternion_to_rotation_matrix (
   input wire logic clock,
   input wire logic reset,
   quat_if.sink     req,
   rot_if.source    rsp
);
   localparam int L = qrm_pkg::LAT;

   logic               vld_ff  [L];
   logic               zero_ff [L];
   logic               adv;
   qrm_pkg::norm_type  norm;
   qrm_pkg::num_type   num   [qrm_pkg::LANES];
   qrm_pkg::entry_type entry [qrm_pkg::LANES];
   qrm_pkg::entry_type rot   [qrm_pkg::LANES];

   // whole pipeline advances unless a finished result is held
   assign adv       = !vld_ff[L-1] || rsp.ready;
   assign req.ready = adv;

   // valid and zero-flag shift lines
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < L; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= (req.quat_w == '0) && (req.quat_x == '0) &&
                       (req.quat_y == '0) && (req.quat_z == '0);
         for (int i = 1; i < L; i++) zero_ff[i] <= zero_ff[i-1];
      end
   end

   qrm_front u_front (
      .clock (clock),
      .en    (adv),
      .w     (req.quat_w),
      .x     (req.quat_x),
      .y     (req.quat_y),
      .z     (req.quat_z),
      .norm  (norm),
      .num   (num)
   );

   for (genvar j = 0; j < qrm_pkg::LANES; j++) begin : g_lane
      qrm_div_lane u_lane (
         .clock (clock),
         .en    (adv),
         .norm  (norm),
         .num   (num[j]),
         .entry (entry[j])
      );
      assign rot[j] = zero_ff[L-1] ? '0 : entry[j];
   end

   // result channel
   assign rsp.valid     = vld_ff[L-1];
   assign rsp.zero_norm = zero_ff[L-1];
   assign rsp.rot_00    = rot[0];
   assign rsp.rot_01    = rot[1];
   assign rsp.rot_02    = rot[2];
   assign rsp.rot_10    = rot[3];
   assign rsp.rot_11    = rot[4];
   assign rsp.rot_12    = rot[5];
   assign rsp.rot_20    = rot[6];
   assign rsp.rot_21    = rot[7];
   assign rsp.rot_22    = rot[8];

`include "quaternion_to_rotation_matrix_assert.svh"

   // a held result blocks new requests
   `QRM_ASSERT_NOW(a_stall_blocks, clock, reset, rsp.valid && !rsp.ready, !req.ready)
   // reset empties the pipeline
   `QRM_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp.valid)
   // a zero-norm result carries an all-zero diagonal
   `QRM_ASSERT_NOW(a_zero_diag, clock, reset, rsp.valid && rsp.zero_norm, rsp.rot_00 == '0 && rsp.rot_11 == '0 && rsp.rot_22 == '0)
endmodule
`default_nettype wire
